/* rtl/cce_pkg.sv */
`default_nettype none

package cce_pkg;

  localparam int unsigned NOTE_COUNT = 96;
  localparam int unsigned IDX_W      = 7;
  localparam int unsigned HZ_W       = 15;
  localparam int unsigned DVD_W      = 15;
  localparam int unsigned DVS_W      = 9;

  localparam logic [IDX_W-1:0] NOISE_NOTE  = IDX_W'(NOTE_COUNT + 1);
  localparam logic [IDX_W-1:0] IDX_NOISE   = 7'd73;
  localparam logic [HZ_W-1:0]  NOISE_HZ    = 15'd4000;
  localparam logic [HZ_W-1:0]  OUT_MAX     = 15'h7FFF;
  localparam logic [14:0]      LFSR_SEED   = 15'h7FFF;
  localparam logic [2:0]       VOLUME_MAX  = 3'd4;
  localparam logic [DVD_W-1:0] GLIDE_NUMER = 15'd128;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_STEP    = 2'd1,
    MODE_NOTE_ON = 2'd2,
    MODE_STOP    = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    CMD_NOP   = 3'd0,
    CMD_ARP   = 3'd1,
    CMD_VIB   = 3'd2,
    CMD_PULSE = 3'd3,
    CMD_ENV   = 3'd4,
    CMD_PORTA = 3'd5,
    CMD_HOP   = 3'd6,
    CMD_RSVD  = 3'd7
  } cmd_e;

  function automatic logic [7:0] duty_level(input logic [1:0] idx);
    logic [7:0] lvl;
    case (idx)
      2'd0:    lvl = 8'd32;
      2'd1:    lvl = 8'd64;
      2'd2:    lvl = 8'd128;
      default: lvl = 8'd192;
    endcase
    return lvl;
  endfunction

  // Index 0 and indexes past the last tone read as silence.
  function automatic logic [12:0] tone_hz(input logic [IDX_W-1:0] idx);
    logic [12:0] hz;
    case (idx)
      7'd0:  hz = 13'd0;
      7'd1:  hz = 13'd65;   7'd2:  hz = 13'd69;   7'd3:  hz = 13'd73;   7'd4:  hz = 13'd78;
      7'd5:  hz = 13'd82;   7'd6:  hz = 13'd87;   7'd7:  hz = 13'd93;   7'd8:  hz = 13'd98;
      7'd9:  hz = 13'd104;  7'd10: hz = 13'd110;  7'd11: hz = 13'd117;  7'd12: hz = 13'd123;
      7'd13: hz = 13'd131;  7'd14: hz = 13'd139;  7'd15: hz = 13'd147;  7'd16: hz = 13'd156;
      7'd17: hz = 13'd165;  7'd18: hz = 13'd175;  7'd19: hz = 13'd185;  7'd20: hz = 13'd196;
      7'd21: hz = 13'd208;  7'd22: hz = 13'd220;  7'd23: hz = 13'd233;  7'd24: hz = 13'd247;
      7'd25: hz = 13'd262;  7'd26: hz = 13'd277;  7'd27: hz = 13'd294;  7'd28: hz = 13'd311;
      7'd29: hz = 13'd330;  7'd30: hz = 13'd349;  7'd31: hz = 13'd370;  7'd32: hz = 13'd392;
      7'd33: hz = 13'd415;  7'd34: hz = 13'd440;  7'd35: hz = 13'd466;  7'd36: hz = 13'd494;
      7'd37: hz = 13'd523;  7'd38: hz = 13'd554;  7'd39: hz = 13'd587;  7'd40: hz = 13'd622;
      7'd41: hz = 13'd659;  7'd42: hz = 13'd698;  7'd43: hz = 13'd740;  7'd44: hz = 13'd784;
      7'd45: hz = 13'd831;  7'd46: hz = 13'd880;  7'd47: hz = 13'd932;  7'd48: hz = 13'd988;
      7'd49: hz = 13'd1047; 7'd50: hz = 13'd1109; 7'd51: hz = 13'd1175; 7'd52: hz = 13'd1245;
      7'd53: hz = 13'd1319; 7'd54: hz = 13'd1397; 7'd55: hz = 13'd1480; 7'd56: hz = 13'd1568;
      7'd57: hz = 13'd1661; 7'd58: hz = 13'd1760; 7'd59: hz = 13'd1865; 7'd60: hz = 13'd1976;
      7'd61: hz = 13'd2093; 7'd62: hz = 13'd2217; 7'd63: hz = 13'd2349; 7'd64: hz = 13'd2489;
      7'd65: hz = 13'd2637; 7'd66: hz = 13'd2794; 7'd67: hz = 13'd2960; 7'd68: hz = 13'd3136;
      7'd69: hz = 13'd3322; 7'd70: hz = 13'd3520; 7'd71: hz = 13'd3729; 7'd72: hz = 13'd3951;
      7'd73: hz = 13'd4186; 7'd74: hz = 13'd4435; 7'd75: hz = 13'd4699; 7'd76: hz = 13'd4978;
      7'd77: hz = 13'd5274; 7'd78: hz = 13'd5588; 7'd79: hz = 13'd5920; 7'd80: hz = 13'd6272;
      7'd81: hz = 13'd6645; 7'd82: hz = 13'd7040; 7'd83: hz = 13'd7459; 7'd84: hz = 13'd7902;
      default: hz = 13'd0;
    endcase
    return hz;
  endfunction

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PRE  = 6'b000010,
    S_VIB  = 6'b000100,
    S_DIV1 = 6'b001000,
    S_DIV2 = 6'b010000,
    S_FIN  = 6'b100000
  } state_e;

endpackage

`default_nettype wire

/* rtl/chiptune_channel_effects.sv */
// Channel     Dir  Handshake                     Payload
// s_axis      in   s_axis_tvalid/s_axis_tready   tuser mode, tdata step and note-on fields
// m_axis      out  m_axis_tvalid/m_axis_tready   tdata out_hz, pwm_duty
// cfg         in   cfg_we_i                      cfg_wdata_i volume
//
// A tick or step beat's result is registered after the two passes of the shared restoring
// divider (128 / speed, then target / (quotient + 1)); the input is ready again as soon as
// the result is registered.
// Note-on and stop beats give no result and leave the input ready.
// The input is not ready while a tick or step is in progress, and such a beat waits in its
// last step while an earlier result is still held in the output register.
// Reset sets all channel state to its initial values at once; there is no clearing pass.
`default_nettype none

module chiptune_channel_effects
  import cce_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  // note[6:0], command[9:7], command_value[17:10], step_duty[19:18],
  // tone_hz[33:20], tone_duty[35:34], tone_ticks[51:36], zero fill above.
  input  wire  [55:0] s_axis_tdata,
  // mode[1:0].
  input  wire  [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  // out_hz[14:0], pwm_duty[22:15], zero fill at bit 23.
  output logic [23:0] m_axis_tdata,
  input  wire         cfg_we_i,
  input  wire  [2:0]  cfg_wdata_i
);

  state_e state_q, state_d;

  logic [2:0]       volume_q;
  logic [HZ_W-1:0]  base_hz_q, base_hz_d;
  logic [1:0]       duty_index_q, duty_index_d;
  logic             noise_on_q, noise_on_d;
  logic             arp_on_q, arp_on_d;
  logic [7:0]       arp_offsets_q, arp_offsets_d;
  logic [1:0]       arp_phase_q, arp_phase_d;
  logic [1:0]       arp_count_q, arp_count_d;
  logic [3:0]       vib_rate_q, vib_rate_d;
  logic [3:0]       vib_amount_q, vib_amount_d;
  logic [3:0]       vib_count_q, vib_count_d;
  logic [2:0]       vib_phase_q, vib_phase_d;
  logic [HZ_W-1:0]  glide_target_q, glide_target_d;
  logic [7:0]       glide_speed_q, glide_speed_d;
  logic [14:0]      noise_shift_q, noise_shift_d;
  logic [16:0]      ticks_left_q, ticks_left_d;
  logic [IDX_W-1:0] base_index_q, base_index_d;
  logic [16:0]      f_q, f_d;
  logic [7:0]       q1_q, q1_d;
  logic             out_valid_q, out_valid_d;
  logic [23:0]      out_data_q, out_data_d;

  logic [1:0]       in_mode;
  logic [6:0]       in_note;
  logic [2:0]       in_cmd;
  logic [7:0]       in_cv;
  logic [1:0]       in_sduty;
  logic [13:0]      in_tone_hz;
  logic [1:0]       in_tone_duty;
  logic [15:0]      in_tone_ticks;
  logic             accept;

  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_dividend;
  logic [DVS_W-1:0] div_divisor;
  logic [DVD_W-1:0] div_quotient;

  logic             tick_ends;
  logic [HZ_W-1:0]  step_hz;
  logic [2:0]       arp_cnt_inc;
  logic [1:0]       arp_ph_new;
  logic [7:0]       arp_sum;
  logic [IDX_W-1:0] arp_idx;
  logic [3:0]       vib_cnt_inc;
  logic [3:0]       vib_limit;
  logic [2:0]       vib_ph_new;
  logic [20:0]      vib_prod;
  logic [16:0]      vib_off;
  logic [HZ_W-1:0]  glide_step;
  logic [HZ_W:0]    glide_up;
  logic [HZ_W:0]    glide_lim;
  logic [HZ_W-1:0]  glide_hz;
  logic             lfsr_bit;
  logic [16:0]      f_fin;
  logic [HZ_W-1:0]  f_sat;
  logic [10:0]      pwm_prod;
  logic [7:0]       pwm;

  assign in_mode       = s_axis_tuser;
  assign in_note       = s_axis_tdata[6:0];
  assign in_cmd        = s_axis_tdata[9:7];
  assign in_cv         = s_axis_tdata[17:10];
  assign in_sduty      = s_axis_tdata[19:18];
  assign in_tone_hz    = s_axis_tdata[33:20];
  assign in_tone_duty  = s_axis_tdata[35:34];
  assign in_tone_ticks = s_axis_tdata[51:36];

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tick_ends   = (ticks_left_q == 17'd1);
  assign arp_cnt_inc = {1'b0, arp_count_q} + 3'd1;
  assign arp_ph_new  = (arp_cnt_inc >= 3'd2) ? ((arp_phase_q == 2'd2) ? 2'd0 : arp_phase_q + 2'd1)
                                             : arp_phase_q;
  assign vib_cnt_inc = vib_count_q + 4'd1;
  assign vib_limit   = 4'd8 - vib_rate_q;
  assign vib_ph_new  = (vib_rate_q[3] || (vib_cnt_inc >= vib_limit)) ? vib_phase_q + 3'd1
                                                                      : vib_phase_q;
  assign vib_prod    = f_q * {17'd0, vib_amount_q};
  assign vib_off     = vib_prod[20:6] == '0 ? 17'd0 : {2'b00, vib_prod[20:6]};

  assign glide_step  = (div_quotient == '0) ? 15'd1 : div_quotient;
  assign glide_up    = {1'b0, base_hz_q} + {1'b0, glide_step};
  assign glide_lim   = {1'b0, glide_step} + {1'b0, glide_target_q};
  assign lfsr_bit    = noise_shift_q[14] ^ noise_shift_q[13];

  always_comb begin
    arp_sum = {1'b0, base_index_q};
    case (arp_ph_new)
      2'd1:    arp_sum = {1'b0, base_index_q} + {4'd0, arp_offsets_q[7:4]};
      2'd2:    arp_sum = {1'b0, base_index_q} + {4'd0, arp_offsets_q[3:0]};
      default: arp_sum = {1'b0, base_index_q};
    endcase
    arp_idx = (arp_sum > 8'(NOTE_COUNT)) ? IDX_W'(NOTE_COUNT) : arp_sum[IDX_W-1:0];
  end

  always_comb begin
    if (in_note == NOISE_NOTE) begin
      step_hz = NOISE_HZ;
    end else if (in_note != '0 && in_note <= IDX_W'(NOTE_COUNT)) begin
      step_hz = {2'b00, tone_hz(in_note)};
    end else begin
      step_hz = '0;
    end
  end

  always_comb begin
    if (glide_speed_q != '0 && base_hz_q != glide_target_q && glide_target_q != '0) begin
      if (base_hz_q < glide_target_q) begin
        glide_hz = (glide_up > {1'b0, glide_target_q}) ? glide_target_q : glide_up[HZ_W-1:0];
      end else begin
        glide_hz = ({1'b0, base_hz_q} < glide_lim) ? glide_target_q : base_hz_q - glide_step;
      end
    end else begin
      glide_hz = base_hz_q;
    end
  end

  always_comb begin
    state_d        = state_q;
    base_hz_d      = base_hz_q;
    duty_index_d   = duty_index_q;
    noise_on_d     = noise_on_q;
    arp_on_d       = arp_on_q;
    arp_offsets_d  = arp_offsets_q;
    arp_phase_d    = arp_phase_q;
    arp_count_d    = arp_count_q;
    vib_rate_d     = vib_rate_q;
    vib_amount_d   = vib_amount_q;
    vib_count_d    = vib_count_q;
    vib_phase_d    = vib_phase_q;
    glide_target_d = glide_target_q;
    glide_speed_d  = glide_speed_q;
    noise_shift_d  = noise_shift_q;
    ticks_left_d   = ticks_left_q;
    base_index_d   = base_index_q;
    f_d            = f_q;
    q1_d           = q1_q;
    out_valid_d    = out_valid_q && !m_axis_tready;
    out_data_d     = out_data_q;
    div_start      = 1'b0;
    div_dividend   = GLIDE_NUMER;
    div_divisor    = {1'b0, glide_speed_q};
    f_fin          = '0;
    f_sat          = '0;
    pwm_prod       = '0;
    pwm            = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_NOTE_ON: begin
              base_hz_d    = {1'b0, in_tone_hz};
              duty_index_d = in_tone_duty;
              noise_on_d   = 1'b0;
              arp_on_d     = 1'b0;
              vib_rate_d   = '0;
              ticks_left_d = (in_tone_ticks == '0) ? 17'h10000 : {1'b0, in_tone_ticks};
            end
            MODE_STOP: begin
              base_hz_d    = '0;
              ticks_left_d = '0;
              noise_on_d   = 1'b0;
              arp_on_d     = 1'b0;
            end
            MODE_STEP: begin
              arp_on_d      = 1'b0;
              vib_rate_d    = '0;
              vib_amount_d  = '0;
              glide_speed_d = '0;
              noise_on_d    = (in_note == NOISE_NOTE);
              base_hz_d     = step_hz;
              duty_index_d  = in_sduty;
              if (in_note == NOISE_NOTE) begin
                base_index_d = IDX_NOISE;
              end else if (step_hz != '0) begin
                base_index_d = in_note;
              end else begin
                base_index_d = 7'd1;
              end
              case (in_cmd)
                CMD_ARP: begin
                  arp_on_d      = 1'b1;
                  arp_offsets_d = in_cv;
                  arp_phase_d   = '0;
                  arp_count_d   = '0;
                end
                CMD_VIB: begin
                  vib_rate_d   = in_cv[7:4];
                  vib_amount_d = in_cv[3:0];
                  vib_count_d  = '0;
                  vib_phase_d  = '0;
                end
                CMD_PULSE: duty_index_d = in_cv[1:0];
                CMD_PORTA: begin
                  glide_speed_d  = in_cv;
                  glide_target_d = step_hz;
                end
                default: ;
              endcase
              state_d = S_PRE;
            end
            default: state_d = S_PRE;
          endcase
        end
      end
      S_PRE: begin
        if (ticks_left_q != '0 && !ticks_left_q[16]) begin
          ticks_left_d = ticks_left_q - 17'd1;
        end
        f_d = tick_ends ? 17'd0 : {2'b00, base_hz_q};
        if (tick_ends) begin
          base_hz_d = '0;
        end
        if (arp_on_q && base_index_q != '0) begin
          arp_count_d = (arp_cnt_inc >= 3'd2) ? 2'd0 : arp_cnt_inc[1:0];
          arp_phase_d = arp_ph_new;
          if (arp_ph_new != 2'd3) begin
            f_d = {4'd0, tone_hz(arp_idx)};
          end
        end
        state_d = S_VIB;
      end
      S_VIB: begin
        if (vib_rate_q != '0 && vib_amount_q != '0 && f_q != '0) begin
          vib_count_d = (vib_rate_q[3] || (vib_cnt_inc >= vib_limit)) ? 4'd0 : vib_cnt_inc;
          vib_phase_d = vib_ph_new;
          if (!vib_ph_new[2]) begin
            f_d = f_q + vib_off;
          end else begin
            f_d = (f_q >= vib_off) ? f_q - vib_off : 17'd0;
          end
        end
        div_start = 1'b1;
        state_d   = S_DIV1;
      end
      S_DIV1: begin
        if (div_done) begin
          q1_d         = div_quotient[7:0];
          div_start    = 1'b1;
          div_dividend = glide_target_q;
          div_divisor  = {1'b0, div_quotient[7:0]} + 9'd1;
          state_d      = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_done) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_q || m_axis_tready) begin
          f_fin     = f_q;
          base_hz_d = glide_hz;
          if (glide_hz != base_hz_q) begin
            f_fin = {2'b00, glide_hz};
          end
          if (noise_on_q) begin
            noise_shift_d = {noise_shift_q[13:0], lfsr_bit};
            f_fin         = lfsr_bit ? {2'b00, NOISE_HZ} : 17'd0;
          end
          f_sat    = (f_fin > {2'b00, OUT_MAX}) ? OUT_MAX : f_fin[HZ_W-1:0];
          pwm_prod = duty_level(duty_index_q) * {8'd0, volume_q};
          pwm      = (f_sat == '0) ? 8'd0 : pwm_prod[9:2];
          out_data_d  = {1'b0, pwm, f_sat};
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  cce_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      volume_q       <= VOLUME_MAX;
      base_hz_q      <= '0;
      duty_index_q   <= 2'd2;
      noise_on_q     <= 1'b0;
      arp_on_q       <= 1'b0;
      arp_offsets_q  <= '0;
      arp_phase_q    <= '0;
      arp_count_q    <= '0;
      vib_rate_q     <= '0;
      vib_amount_q   <= '0;
      vib_count_q    <= '0;
      vib_phase_q    <= '0;
      glide_target_q <= '0;
      glide_speed_q  <= '0;
      noise_shift_q  <= LFSR_SEED;
      ticks_left_q   <= '0;
      base_index_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      if (cfg_we_i) begin
        volume_q <= (cfg_wdata_i > VOLUME_MAX) ? VOLUME_MAX : cfg_wdata_i;
      end
      base_hz_q      <= base_hz_d;
      duty_index_q   <= duty_index_d;
      noise_on_q     <= noise_on_d;
      arp_on_q       <= arp_on_d;
      arp_offsets_q  <= arp_offsets_d;
      arp_phase_q    <= arp_phase_d;
      arp_count_q    <= arp_count_d;
      vib_rate_q     <= vib_rate_d;
      vib_amount_q   <= vib_amount_d;
      vib_count_q    <= vib_count_d;
      vib_phase_q    <= vib_phase_d;
      glide_target_q <= glide_target_d;
      glide_speed_q  <= glide_speed_d;
      noise_shift_q  <= noise_shift_d;
      ticks_left_q   <= ticks_left_d;
      base_index_q   <= base_index_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    f_q        <= f_d;
    q1_q       <= q1_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (in_mode == MODE_TICK || in_mode == MODE_STEP) |=> !s_axis_tready)
    else $error("input ready right after a tick beat");

  a_div_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_DIV1 || state_q == S_DIV2))
    else $error("divider finished outside a divide step");

  a_volume_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    volume_q <= VOLUME_MAX)
    else $error("volume above four");

  a_arp_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    arp_phase_q != 2'd3)
    else $error("arpeggio phase out of range");

  a_glide_q1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV2 && glide_speed_q != '0 |-> q1_q <= 8'd128)
    else $error("glide quotient out of range");

endmodule

`default_nettype wire

/* rtl/cce_divider.sv */
`default_nettype none

module cce_divider
  import cce_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire  [DVD_W-1:0] dividend_i,
  input  wire  [DVS_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o
);

  logic [DVD_W-1:0] quo_q, quo_d;
  logic [DVS_W-2:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q;
  logic [3:0]       cnt_q, cnt_d;
  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [DVS_W-1:0] trial;
  logic             fits;

  assign trial = {rem_q, quo_q[DVD_W-1]};
  assign fits  = (trial >= dvs_q);

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      quo_d  = dividend_i;
      rem_d  = '0;
      cnt_d  = 4'(DVD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      rem_d  = fits ? (DVS_W-1)'(trial - dvs_q) : trial[DVS_W-2:0];
      quo_d  = {quo_q[DVD_W-2:0], fits};
      cnt_d  = cnt_q - 4'd1;
      if (cnt_q == 4'd1) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    if (start_i) begin
      dvs_q <= divisor_i;
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

`default_nettype wire

/* dv/chiptune_channel_effects_tb.sv */
`default_nettype none

module chiptune_channel_effects_tb;
  import cce_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned DRAIN_CYCLES = 80;

  typedef struct packed {
    logic [1:0]  mode;
    logic [55:0] data;
  } beat_t;

  typedef struct packed {
    logic [7:0]  pwm;
    logic [14:0] hz;
  } tone_out_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [55:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_wdata_i = '0;

  always #2 clk_i = ~clk_i;

  chiptune_channel_effects dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_we_i(cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  // Channel state mirrored at full integer width.
  int unsigned ch_volume, ch_base_hz, ch_duty, ch_noise, ch_arp, ch_arp_ofs;
  int unsigned ch_arp_phase, ch_arp_cnt, ch_vib_rate, ch_vib_amt, ch_vib_cnt, ch_vib_phase;
  int unsigned ch_glide_tgt, ch_glide_spd, ch_lfsr, ch_ticks_left, ch_base_idx;

  beat_t pending_beats[$];
  tone_out_t expected_tones[$];
  int unsigned mismatches = 0;
  bit quiet_phase = 1'b0;
  bit hold_off_req = 1'b0;
  bit in_taken = 1'b0;

  function automatic int unsigned note_hz(int unsigned idx);
    int unsigned tbl[84] = '{
      65, 69, 73, 78, 82, 87, 93, 98, 104, 110, 117, 123,
      131, 139, 147, 156, 165, 175, 185, 196, 208, 220, 233, 247,
      262, 277, 294, 311, 330, 349, 370, 392, 415, 440, 466, 494,
      523, 554, 587, 622, 659, 698, 740, 784, 831, 880, 932, 988,
      1047, 1109, 1175, 1245, 1319, 1397, 1480, 1568, 1661, 1760, 1865, 1976,
      2093, 2217, 2349, 2489, 2637, 2794, 2960, 3136, 3322, 3520, 3729, 3951,
      4186, 4435, 4699, 4978, 5274, 5588, 5920, 6272, 6645, 7040, 7459, 7902};
    if (idx == 0) return 0;
    if (idx > 96) idx = 96;
    if (idx > 84) return 0;
    return tbl[idx-1];
  endfunction

  function automatic int unsigned semitone_hz(int unsigned semis);
    int unsigned i;
    i = ch_base_idx + semis;
    if (i < 1) i = 1;
    if (i > NOTE_COUNT) i = NOTE_COUNT;
    return note_hz(i);
  endfunction

  function automatic int unsigned level_of(int unsigned idx);
    int unsigned lv[4] = '{32, 64, 128, 192};
    return lv[idx & 3];
  endfunction

  task automatic channel_reset();
    ch_volume = 4; ch_base_hz = 0; ch_duty = 2; ch_noise = 0; ch_arp = 0; ch_arp_ofs = 0;
    ch_arp_phase = 0; ch_arp_cnt = 0; ch_vib_rate = 0; ch_vib_amt = 0; ch_vib_cnt = 0;
    ch_vib_phase = 0; ch_glide_tgt = 0; ch_glide_spd = 0; ch_lfsr = 'h7FFF;
    ch_ticks_left = 0; ch_base_idx = 0;
  endtask

  task automatic load_step(int unsigned note, cmd_e cmd, int unsigned val, int unsigned sduty);
    ch_arp = 0; ch_vib_rate = 0; ch_vib_amt = 0; ch_glide_spd = 0; ch_noise = 0;
    if (note == NOTE_COUNT + 1) begin
      ch_noise = 1;
      ch_base_hz = NOISE_HZ;
    end else if (note >= 1 && note <= NOTE_COUNT) begin
      ch_base_hz = note_hz(note);
    end else begin
      ch_base_hz = 0;
    end
    ch_duty = sduty;
    case (cmd)
      CMD_ARP: begin
        ch_arp = 1; ch_arp_ofs = val; ch_arp_phase = 0; ch_arp_cnt = 0;
      end
      CMD_VIB: begin
        ch_vib_rate = val >> 4; ch_vib_amt = val & 15; ch_vib_cnt = 0; ch_vib_phase = 0;
      end
      CMD_PULSE: ch_duty = val & 3;
      CMD_PORTA: begin
        ch_glide_spd = val; ch_glide_tgt = ch_base_hz;
      end
      default: ;
    endcase
    ch_base_idx = 0;
    for (int unsigned i = 1; i <= NOTE_COUNT; i++) begin
      if (note_hz(i) >= ch_base_hz) begin
        ch_base_idx = i;
        break;
      end
    end
  endtask

  task automatic predict_beat(beat_t b);
    int unsigned f, off, st, bit_in, t;
    tone_out_t r;
    case (mode_e'(b.mode))
      MODE_NOTE_ON: begin
        t = b.data[51:36];
        ch_base_hz = b.data[33:20]; ch_duty = b.data[35:34];
        ch_noise = 0; ch_arp = 0; ch_vib_rate = 0;
        ch_ticks_left = (t == 0) ? 'h10000 : t;
        return;
      end
      MODE_STOP: begin
        ch_base_hz = 0; ch_ticks_left = 0; ch_noise = 0; ch_arp = 0;
        return;
      end
      MODE_STEP: load_step(b.data[6:0], cmd_e'(b.data[9:7]), b.data[17:10], b.data[19:18]);
      default: ;
    endcase
    if (ch_ticks_left > 0 && ch_ticks_left < 'h10000) begin
      ch_ticks_left--;
      if (ch_ticks_left == 0) ch_base_hz = 0;
    end
    f = ch_base_hz;
    if (ch_arp != 0 && ch_base_idx > 0) begin
      ch_arp_cnt++;
      if (ch_arp_cnt >= 2) begin
        ch_arp_cnt = 0;
        ch_arp_phase = (ch_arp_phase + 1) % 3;
      end
      if (ch_arp_phase == 0) f = note_hz(ch_base_idx);
      else if (ch_arp_phase == 1) f = semitone_hz(ch_arp_ofs >> 4);
      else f = semitone_hz(ch_arp_ofs & 15);
    end
    if (ch_vib_rate > 0 && ch_vib_amt > 0 && f > 0) begin
      ch_vib_cnt = (ch_vib_cnt + 1) & 15;
      if (int'(ch_vib_cnt) >= 8 - int'(ch_vib_rate)) begin
        ch_vib_cnt = 0;
        ch_vib_phase = (ch_vib_phase + 1) & 7;
      end
      off = f * ch_vib_amt / 64;
      if (ch_vib_phase < 4) f += off;
      else f = (f >= off) ? f - off : 0;
    end
    if (ch_glide_spd > 0 && ch_base_hz != ch_glide_tgt && ch_glide_tgt > 0) begin
      st = ch_glide_tgt / (128 / ch_glide_spd + 1);
      if (st == 0) st = 1;
      if (ch_base_hz < ch_glide_tgt)
        ch_base_hz = (ch_base_hz + st > ch_glide_tgt) ? ch_glide_tgt : ch_base_hz + st;
      else
        ch_base_hz = (ch_base_hz < st + ch_glide_tgt) ? ch_glide_tgt : ch_base_hz - st;
      f = ch_base_hz;
    end
    if (ch_noise != 0) begin
      bit_in = ((ch_lfsr >> 14) ^ (ch_lfsr >> 13)) & 1;
      ch_lfsr = ((ch_lfsr << 1) | bit_in) & 'h7FFF;
      f = bit_in ? NOISE_HZ : 0;
    end
    if (f > OUT_MAX) f = OUT_MAX;
    r.hz = 15'(f);
    r.pwm = (f == 0) ? 8'd0 : 8'((level_of(ch_duty) * ch_volume / 4) & 255);
    expected_tones.push_back(r);
  endtask

  function automatic beat_t make_beat(mode_e m, int unsigned note, cmd_e cmd,
                                      int unsigned val, int unsigned sduty,
                                      int unsigned hz, int unsigned tduty,
                                      int unsigned ticks);
    beat_t b;
    b.mode = m;
    b.data = '0;
    b.data[6:0] = 7'(note);
    b.data[9:7] = cmd;
    b.data[17:10] = 8'(val);
    b.data[19:18] = 2'(sduty);
    b.data[33:20] = 14'(hz);
    b.data[35:34] = 2'(tduty);
    b.data[51:36] = 16'(ticks);
    return b;
  endfunction

  function automatic beat_t random_beat();
    int unsigned r, note;
    mode_e m;
    r = $urandom_range(0, 99);
    if (r < 40) m = MODE_TICK;
    else if (r < 80) m = MODE_STEP;
    else if (r < 93) m = MODE_NOTE_ON;
    else m = MODE_STOP;
    r = $urandom_range(0, 9);
    note = (r == 0) ? 0 : (r == 1) ? NOTE_COUNT + 1 : (r == 2) ? $urandom_range(98, 127)
         : $urandom_range(1, NOTE_COUNT);
    r = $urandom_range(0, 3);
    return make_beat(m, note, cmd_e'($urandom_range(0, 7)), $urandom_range(0, 255),
                     $urandom_range(0, 3),
                     (r == 0) ? $urandom_range(0, 16383) : $urandom_range(0, 9000),
                     $urandom_range(0, 3),
                     (r == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 12));
  endfunction

  // Sender: presents queued beats, holds a beat until it is taken, and idles in short
  // random bursts.
  int unsigned send_gap = 0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        void'(pending_beats.pop_front());
      end
      if (s_axis_tvalid && !in_taken) begin
        s_axis_tvalid <= 1'b1;
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 7) == 0) begin
        send_gap <= $urandom_range(0, 3);
        s_axis_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= pending_beats[0].mode;
        s_axis_tdata <= pending_beats[0].data;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stall bursts, plus one long hold-off on request.
  int unsigned recv_gap = 0;
  int unsigned hold_cnt = 0;
  bit hold_done = 1'b0;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_off_req && !hold_done) begin
        hold_done <= 1'b1;
        hold_cnt <= 400;
        m_axis_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
        recv_gap <= $urandom_range(0, 3);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Predictor and output checker.
  int unsigned idle_cycles = 0;
  always @(posedge clk_i) begin
    tone_out_t got, want;
    bit progress;
    if (rst_ni) begin
      progress = 1'b0;
      in_taken <= s_axis_tvalid && s_axis_tready;
      if (s_axis_tvalid && s_axis_tready) begin
        predict_beat(beat_t'({s_axis_tuser, s_axis_tdata}));
        progress = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        progress = 1'b1;
        got = m_axis_tdata[22:0];
        if (expected_tones.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected beat: hz=%0d pwm=%0d", got.hz, got.pwm);
        end else begin
          want = expected_tones.pop_front();
          if (got.hz !== want.hz || got.pwm !== want.pwm || m_axis_tdata[23] !== 1'b0) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: hz exp %0d got %0d, pwm exp %0d got %0d",
                       want.hz, got.hz, want.pwm, got.pwm);
          end
        end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_beats.size() > 0 || s_axis_tvalid || expected_tones.size() > 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_volume(int unsigned v);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= 3'(v);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    ch_volume = (v > 4) ? 4 : v;
  endtask

  initial begin
    int unsigned vols[6] = '{4, 0, 7, 1, 3, 2};
    channel_reset();
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 1, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 96, CMD_PULSE, 255, 1, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 0, CMD_ENV, 0, 3, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 97, CMD_HOP, 0, 2, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 127, CMD_RSVD, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 90, CMD_ARP, 8'hFF, 2, 0, 0, 0));
    for (int i = 0; i < 4; i++)
      pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 40, CMD_VIB, 8'hFF, 3, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 40, CMD_VIB, 8'h1F, 3, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 60, CMD_PORTA, 1, 2, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_NOTE_ON, 0, CMD_NOP, 0, 0, 16383, 3, 2));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STEP, 30, CMD_PORTA, 255, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_NOTE_ON, 0, CMD_NOP, 0, 0, 0, 0, 65535));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_NOTE_ON, 0, CMD_NOP, 0, 0, 100, 1, 0));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_STOP, 0, CMD_NOP, 0, 0, 0, 0, 0));
    pending_beats.push_back(make_beat(MODE_TICK, 0, CMD_NOP, 0, 0, 0, 0, 0));
    wait_drained();

    foreach (vols[v]) begin
      write_volume(vols[v]);
      for (int i = 0; i < 180; i++) pending_beats.push_back(random_beat());
      if (v == 2) hold_off_req = 1'b1;
      if (v == 5) quiet_phase = 1'b1;
      wait_drained();
    end

    if (mismatches == 0 && expected_tones.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
